// File: rtl/core/multi_reader_receive_ring_macros.svh
// Assertion macros shared by the receive ring RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef MULTI_READER_RECEIVE_RING_MACROS_SVH
`define MULTI_READER_RECEIVE_RING_MACROS_SVH

// same-cycle implication, disabled during reset
`define MRR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mrr: same-cycle check failed");

// next-cycle implication, disabled during reset
`define MRR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mrr: next-cycle check failed");

`endif

// File: rtl/core/mrr_pkg.sv
// Types and constants for the multi-reader receive ring.
// No dependencies; imported by the ring top level.
package mrr_pkg;

   typedef enum logic [1:0] {
      MODE_RECEIVE = 2'd0,
      MODE_READ    = 2'd1,
      MODE_DISCARD = 2'd2,
      MODE_CHECK   = 2'd3
   } mode_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_DATA = 1'b1
   } state_type;

   // most bytes delivered for one read item
   localparam logic [3:0] MAX_OUT = 4'd15;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       byte_valid;
      logic       overflow_seen;
      logic [3:0] buffered;
      logic       last;
   } rsp_type;

endpackage

// File: rtl/core/multi_reader_receive_ring.sv
// Multi-reader receive ring. A receive item (mode 0) stores its byte and
// gives no result; any reader it laps gets a sticky overflow flag and loses what it had
// pending. Discard, check and out-of-range items give one result each.
// A read of n bytes (n = min(count, pending, 15), at least one result) first issues a
// byte store read, then gives one byte per cycle while rsp_tready holds, since the next
// store read is issued in the cycle a byte moves into the result register. A new item is
// taken only when the result register is free or being emptied; rsp_tready low stalls
// the read sequence. The byte store needs no clearing after reset.
`include "multi_reader_receive_ring_macros.svh"

module multi_reader_receive_ring #(
   parameter int DEPTH   = 16,
   parameter int READERS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // reader[2:0], rx_byte[10:3], count[15:11]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_byte[7:0], buffered[11:8], zero[15:12]
   output logic [1:0]  rsp_tuser,   // byte_valid[0], overflow_seen[1]
   output logic        rsp_tlast    // last
);

   import mrr_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;

   state_type            state_ff, state_in;
   logic [PW-1:0]        wp_ff, wp_in;
   logic [PW-1:0]        rp_ff [READERS];
   logic [PW-1:0]        rp_in [READERS];
   logic [READERS-1:0]   flag_ff, flag_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic [RW-1:0]        cur_ff, cur_in;
   rsp_type              out_ff, out_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;

   mode_type             mode;
   logic [2:0]           rdr;
   logic [7:0]           rx_byte;
   logic [4:0]           count;
   logic                 in_range;
   logic [RW-1:0]        req_idx, sel_idx;
   logic [PW-1:0]        rp_sel, rp_adv, wp_next;
   logic [PW:0]          wp_x, rp_x;
   logic [PW-1:0]        pend;
   logic [PW+3:0]        pend_x;
   logic [3:0]           avail4, count4, n4;
   logic                 out_free, accept;
   logic                 wr_en, rd_en;
   logic [7:0]           rd_data;

   assign mode     = mode_type'(req_tuser);
   assign rdr      = req_tdata[2:0];
   assign rx_byte  = req_tdata[10:3];
   assign count    = req_tdata[15:11];
   assign in_range = {29'b0, rdr} < 32'(READERS);
   assign req_idx  = RW'(rdr);

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign sel_idx  = (state_ff == S_IDLE) ? req_idx : cur_ff;
   assign rp_sel   = rp_ff[sel_idx];
   assign rp_adv   = (rp_sel == PW'(DEPTH - 1)) ? '0 : rp_sel + PW'(1);
   assign wp_next  = (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + PW'(1);

   // pending = (wp - rp) mod DEPTH, DEPTH need not be a power of two
   assign wp_x   = {1'b0, wp_ff};
   assign rp_x   = {1'b0, rp_sel};
   assign pend   = PW'((wp_x >= rp_x) ? (wp_x - rp_x) : (wp_x + (PW+1)'(DEPTH) - rp_x));
   assign pend_x = (PW+4)'(pend);
   assign avail4 = (pend_x > (PW+4)'(MAX_OUT)) ? MAX_OUT : pend_x[3:0];
   assign count4 = (count > 5'(MAX_OUT)) ? MAX_OUT : count[3:0];
   assign n4     = (count4 < avail4) ? count4 : avail4;

   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   mrr_byte_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rp_sel),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      flag_in       = flag_ff;
      cnt_in        = cnt_ff;
      cur_in        = cur_ff;
      out_in        = out_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      wr_en         = 1'b0;
      rd_en         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (mode == MODE_RECEIVE) begin
                  wr_en = 1'b1;
                  // a reader sitting on the new write position is lapped
                  for (int i = 0; i < READERS; i++) begin
                     if (rp_ff[i] == wp_next) begin
                        flag_in[i] = 1'b1;
                     end
                  end
                  wp_in = wp_next;
               end else if (!in_range) begin
                  out_in        = '{read_byte: 8'd0, byte_valid: 1'b0, overflow_seen: 1'b0,
                                    buffered: 4'd0, last: 1'b1};
                  rsp_tvalid_in = 1'b1;
               end else begin
                  case (mode)
                     MODE_READ: begin
                        if (n4 == 4'd0) begin
                           out_in        = '{read_byte: 8'd0, byte_valid: 1'b0,
                                             overflow_seen: flag_ff[sel_idx],
                                             buffered: pend_x[3:0], last: 1'b1};
                           rsp_tvalid_in = 1'b1;
                        end else begin
                           rd_en          = 1'b1;
                           rp_in[sel_idx] = rp_adv;
                           cnt_in         = n4;
                           cur_in         = req_idx;
                           state_in       = S_DATA;
                        end
                     end
                     MODE_DISCARD: begin
                        rp_in[sel_idx]   = wp_ff;
                        flag_in[sel_idx] = 1'b0;
                        out_in           = '{read_byte: 8'd0, byte_valid: 1'b0,
                                             overflow_seen: flag_ff[sel_idx],
                                             buffered: 4'd0, last: 1'b1};
                        rsp_tvalid_in    = 1'b1;
                     end
                     default: begin
                        flag_in[sel_idx] = 1'b0;
                        out_in           = '{read_byte: 8'd0, byte_valid: 1'b0,
                                             overflow_seen: flag_ff[sel_idx],
                                             buffered: pend_x[3:0], last: 1'b1};
                        rsp_tvalid_in    = 1'b1;
                     end
                  endcase
               end
            end
         end
         S_DATA: begin
            // rp already points past the byte in rd_data
            if (out_free) begin
               out_in        = '{read_byte: rd_data, byte_valid: 1'b1,
                                 overflow_seen: flag_ff[sel_idx],
                                 buffered: pend_x[3:0], last: (cnt_ff == 4'd1)};
               rsp_tvalid_in = 1'b1;
               cnt_in        = cnt_ff - 4'd1;
               if (cnt_ff == 4'd1) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en          = 1'b1;
                  rp_in[sel_idx] = rp_adv;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wp_ff         <= '0;
         flag_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < READERS; i++) begin
            rp_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         flag_ff       <= flag_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rp_ff         <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'd0, out_ff.buffered, out_ff.read_byte};
   assign rsp_tuser  = {out_ff.overflow_seen, out_ff.byte_valid};
   assign rsp_tlast  = out_ff.last;

   `MRR_ASSERT_IMP(a_data_count, clock, reset, state_ff == S_DATA, cnt_ff != 4'd0)
   `MRR_ASSERT_IMP(a_wp_range, clock, reset, 1'b1, wp_ff <= PW'(DEPTH - 1))
   `MRR_ASSERT_IMP(a_empty_rsp, clock, reset, rsp_tvalid_ff && !out_ff.byte_valid, out_ff.last && (out_ff.read_byte == 8'd0))
   `MRR_ASSERT_NXT(a_read_end, clock, reset, (state_ff == S_DATA) && out_free && (cnt_ff == 4'd1), (state_ff == S_IDLE) && rsp_tvalid_ff && out_ff.last)

endmodule

// File: rtl/core/mrr_byte_store.sv
// Byte store of the receive ring: one write port, one read port with
// registered read data. Standalone, no package needed.
module mrr_byte_store #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
